// File: rtl/wfpa_pkg.sv
`default_nettype none
package wfpa_pkg;

  // Fixed widths cover the largest heap the block supports, plus sum headroom.
  localparam int SIZE_W = 26;
  localparam int IDX_W  = 8;
  localparam int CNT_W  = 9;
  localparam int HDR_W  = 7;
  localparam int TOT_W  = 17;
  localparam int REQ_W  = 17;
  localparam int OFF_W  = 16;

  localparam logic [TOT_W-1:0] TOTAL_RESET  = 17'd4096;
  localparam logic [HDR_W-1:0] HEADER_RESET = 7'd16;
  localparam logic [SIZE_W-1:0] GRAIN       = 26'd4;

  localparam logic REG_TOTAL  = 1'b0;
  localparam logic REG_HEADER = 1'b1;
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_FREE    = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              used;
    logic [SIZE_W-1:0] offset;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef enum logic [5:0] {
    C_NOP   = 6'b000001,
    C_INIT  = 6'b000010,
    C_SPLIT = 6'b000100,
    C_USE   = 6'b001000,
    C_FREE  = 6'b010000,
    C_MERGE = 6'b100000
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t         code;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] need;
    logic [SIZE_W-1:0] hdr;
    logic [SIZE_W-1:0] init_size;
    logic [OFF_W-1:0]  rel;
    logic              scan_free;
  } cmd_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] offset;
    logic              lfree;
    logic              rfree;
  } cand_t;

endpackage
`default_nettype wire

// File: rtl/wfpa_cell.sv
`default_nettype none
module wfpa_cell import wfpa_pkg::*; #(
  parameter int POS = 0
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cmd_t   cmd,
  input  wire entry_t left,
  input  wire entry_t right,
  input  wire cand_t  cand_in,
  output entry_t      ent,
  output cand_t       cand_out
);

  entry_t ent_next;
  cand_t  cand_next;
  logic [IDX_W:0] p;
  logic [IDX_W:0] i;
  logic [SIZE_W-1:0] data_sum;
  logic match_alloc;
  logic match_free;
  logic take;

  assign p = (IDX_W+1)'(POS);
  assign i = {1'b0, cmd.idx};
  assign data_sum = ent.offset + cmd.hdr;

  always_comb begin
    ent_next = ent;
    case (cmd.code)
      C_INIT: begin
        ent_next = '0;
        if (p == '0) begin
          ent_next.valid = 1'b1;
          ent_next.size  = cmd.init_size;
        end
      end
      C_SPLIT: begin
        if (p == i) begin
          ent_next.size = cmd.need;
          ent_next.used = 1'b1;
        end else if (p == i + 1'b1) begin
          ent_next.valid  = 1'b1;
          ent_next.used   = 1'b0;
          ent_next.offset = left.offset + cmd.hdr + cmd.need;
          ent_next.size   = left.size - cmd.hdr - cmd.need;
        end else if (p > i + 1'b1) begin
          ent_next = left;
        end
      end
      C_USE: begin
        if (p == i) ent_next.used = 1'b1;
      end
      C_FREE: begin
        if (p == i) ent_next.used = 1'b0;
      end
      C_MERGE: begin
        if (p == i) begin
          ent_next.size = ent.size + cmd.hdr + right.size;
        end else if (p > i) begin
          ent_next = right;
        end
      end
      default: ent_next = ent;
    endcase
  end

  // Each cell improves on the candidate handed over by its left neighbor.
  assign match_alloc = ent.valid && !ent.used && (ent.size >= cmd.need);
  assign match_free  = ent.valid && ent.used && (data_sum[OFF_W-1:0] == cmd.rel);
  assign take = cmd.scan_free ? (match_free && !cand_in.found)
                              : (match_alloc && (!cand_in.found || ent.size > cand_in.size));

  always_comb begin
    cand_next = cand_in;
    if (take) begin
      cand_next.found  = 1'b1;
      cand_next.idx    = IDX_W'(POS);
      cand_next.size   = ent.size;
      cand_next.offset = ent.offset;
      cand_next.lfree  = left.valid && !left.used;
      cand_next.rfree  = right.valid && !right.used;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= '0;
    end else begin
      ent <= ent_next;
    end
    cand_out <= cand_next;
  end

endmodule
`default_nettype wire

// File: rtl/worst_fit_partition_allocator.sv
`default_nettype none
// An accepted request starts a scan: the candidate passes down the row of partition
// cells one cell per cycle, then, if a partition was found, a split, use or free command
// updates the row; a free also merges with a free right and then a free left neighbor.
// One transaction is in flight at a time: a new one is accepted only once the previous
// result has been loaded into the output register.
// Reset and every configuration write rebuild the table with an INIT command once idle.
module worst_fit_partition_allocator import wfpa_pkg::*; #(
  parameter int MAX_PARTITIONS = 32,
  parameter int HEAP_BYTES     = 65536
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             op,
  input  wire logic [REQ_W-1:0] request_size,
  input  wire logic [OFF_W-1:0] release_offset,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  ok,
  output logic [OFF_W-1:0]      data_offset,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [TOT_W-1:0] cfg_wdata
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_ACT     = 6'b000100,
    S_MERGE_R = 6'b001000,
    S_MERGE_L = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  localparam int SCAN_W = $clog2(MAX_PARTITIONS + 1);

  state_t state;
  logic [TOT_W-1:0] total;
  logic [HDR_W-1:0] header;
  logic init_req;
  logic [CNT_W-1:0] count;
  logic [SCAN_W-1:0] scan_cnt;
  logic op_q;
  logic [SIZE_W-1:0] need;
  logic [OFF_W-1:0] rel_q;
  cand_t best;
  logic res_ok;
  logic [OFF_W-1:0] res_offset;

  cmd_t cmd;
  entry_t ents [MAX_PARTITIONS];
  cand_t cands [MAX_PARTITIONS];

  logic [SIZE_W-1:0] hdr_w;
  logic [SIZE_W-1:0] total_clip;
  logic [SIZE_W-1:0] req_w;
  logic [SIZE_W-1:0] need_in;
  logic [SIZE_W-1:0] data_sum;
  logic split_ok;
  cand_t last;

  assign hdr_w = SIZE_W'(header);
  assign total_clip = (SIZE_W'(total) > SIZE_W'(HEAP_BYTES)) ? SIZE_W'(HEAP_BYTES)
                                                             : SIZE_W'(total);
  assign req_w = SIZE_W'(request_size);
  assign need_in = (req_w == '0) ? GRAIN : ((req_w + 26'd3) & ~26'd3);
  assign last = cands[MAX_PARTITIONS-1];
  assign data_sum = last.offset + hdr_w;
  assign split_ok = (last.size >= need + hdr_w + GRAIN) &&
                    (count < CNT_W'(MAX_PARTITIONS));

  assign in_ready = (state == S_IDLE) && !init_req;

  always_comb begin
    cmd.code      = C_NOP;
    cmd.idx       = best.idx;
    cmd.need      = need;
    cmd.hdr       = hdr_w;
    cmd.init_size = (total_clip > hdr_w) ? total_clip - hdr_w : '0;
    cmd.rel       = rel_q;
    cmd.scan_free = op_q;
    case (state)
      S_IDLE: begin
        if (init_req) cmd.code = C_INIT;
      end
      S_ACT: begin
        cmd.idx = last.idx;
        if (last.found) begin
          if (op_q == OP_FREE) cmd.code = C_FREE;
          else if (split_ok) cmd.code = C_SPLIT;
          else cmd.code = C_USE;
        end
      end
      S_MERGE_R: begin
        if (best.rfree) cmd.code = C_MERGE;
      end
      S_MERGE_L: begin
        cmd.idx = best.idx - 1'b1;
        if (best.lfree) cmd.code = C_MERGE;
      end
      default: cmd.code = C_NOP;
    endcase
  end

  for (genvar g = 0; g < MAX_PARTITIONS; g++) begin : g_cell
    entry_t l_ent;
    entry_t r_ent;
    cand_t  c_in;
    if (g == 0) begin : g_first
      assign l_ent = '0;
      assign c_in  = '0;
    end else begin : g_mid
      assign l_ent = ents[g-1];
      assign c_in  = cands[g-1];
    end
    if (g == MAX_PARTITIONS - 1) begin : g_last
      assign r_ent = '0;
    end else begin : g_inner
      assign r_ent = ents[g+1];
    end
    wfpa_cell #(.POS(g)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .left     (l_ent),
      .right    (r_ent),
      .cand_in  (c_in),
      .ent      (ents[g]),
      .cand_out (cands[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= TOTAL_RESET;
      header    <= HEADER_RESET;
      init_req  <= 1'b1;
      count     <= '0;
      scan_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_TOTAL) total <= cfg_wdata;
        else header <= cfg_wdata[HDR_W-1:0];
        init_req <= 1'b1;
      end
      case (cmd.code)
        C_INIT:  count <= CNT_W'(1);
        C_SPLIT: count <= count + 1'b1;
        C_MERGE: count <= count - 1'b1;
        default: count <= count;
      endcase
      case (state)
        S_IDLE: begin
          if (init_req) begin
            if (!cfg_we) init_req <= 1'b0;
          end else if (in_valid) begin
            op_q     <= op;
            need     <= need_in;
            rel_q    <= release_offset;
            scan_cnt <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == SCAN_W'(MAX_PARTITIONS)) state <= S_ACT;
        end
        S_ACT: begin
          best       <= last;
          res_ok     <= last.found;
          res_offset <= (last.found && op_q == OP_ALLOC) ? data_sum[OFF_W-1:0] : '0;
          state      <= (last.found && op_q == OP_FREE) ? S_MERGE_R : S_DONE;
        end
        S_MERGE_R: state <= S_MERGE_L;
        S_MERGE_L: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            ok          <= res_ok;
            data_offset <= res_offset;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none

class alloc_scoreboard;
  localparam int ENTRIES = 32;
  localparam int HEAP_MAX = 65536;

  int unsigned total_bytes;
  int unsigned hdr_bytes;
  int unsigned part_off[ENTRIES];
  int unsigned part_size[ENTRIES];
  bit part_used[ENTRIES];
  int unsigned part_count;

  bit exp_ok[$];
  logic [15:0] exp_offset[$];
  int errors;
  int unsigned live_offsets[$];

  function new();
    total_bytes = 4096;
    hdr_bytes = 16;
    errors = 0;
    rebuild();
  endfunction

  function void rebuild();
    int unsigned t;
    t = (total_bytes > HEAP_MAX) ? HEAP_MAX : total_bytes;
    for (int k = 0; k < ENTRIES; k++) begin
      part_off[k] = 0;
      part_size[k] = 0;
      part_used[k] = 0;
    end
    part_size[0] = (t > hdr_bytes) ? t - hdr_bytes : 0;
    part_count = 1;
    live_offsets.delete();
  endfunction

  function void set_reg(bit idx, int unsigned value);
    if (idx == wfpa_pkg::REG_TOTAL) total_bytes = value & 17'h1ffff;
    else hdr_bytes = value & 7'h7f;
    rebuild();
  endfunction

  function void drop_entry(int unsigned idx);
    for (int unsigned k = idx; k + 1 < part_count; k++) begin
      part_off[k] = part_off[k+1];
      part_size[k] = part_size[k+1];
      part_used[k] = part_used[k+1];
    end
    part_count--;
    part_off[part_count] = 0;
    part_size[part_count] = 0;
    part_used[part_count] = 0;
  endfunction

  // Computes the expected result of one accepted transaction.
  function void note_request(bit op, int unsigned req, int unsigned rel);
    int unsigned need, best, k;
    bit found;
    if (op == wfpa_pkg::OP_ALLOC) begin
      need = (req == 0) ? 4 : ((req + 3) & ~32'd3);
      found = 0;
      best = 0;
      for (k = 0; k < part_count; k++) begin
        if (part_used[k] || part_size[k] < need) continue;
        if (!found || part_size[k] > part_size[best]) begin
          best = k;
          found = 1;
        end
      end
      if (!found) begin
        exp_ok.push_back(0);
        exp_offset.push_back(0);
        return;
      end
      if (part_size[best] >= need + hdr_bytes + 4 && part_count < ENTRIES) begin
        for (k = part_count; k > best + 1; k--) begin
          part_off[k] = part_off[k-1];
          part_size[k] = part_size[k-1];
          part_used[k] = part_used[k-1];
        end
        part_off[best+1] = part_off[best] + hdr_bytes + need;
        part_size[best+1] = part_size[best] - hdr_bytes - need;
        part_used[best+1] = 0;
        part_count++;
        part_size[best] = need;
      end
      part_used[best] = 1;
      exp_ok.push_back(1);
      exp_offset.push_back((part_off[best] + hdr_bytes) & 16'hffff);
      live_offsets.push_back((part_off[best] + hdr_bytes) & 16'hffff);
    end else begin
      for (k = 0; k < part_count; k++)
        if (part_used[k] && ((part_off[k] + hdr_bytes) & 16'hffff) == rel) break;
      exp_offset.push_back(0);
      if (k < part_count) begin
        part_used[k] = 0;
        k = 0;
        while (k + 1 < part_count) begin
          if (!part_used[k] && !part_used[k+1]) begin
            part_size[k] = part_size[k] + hdr_bytes + part_size[k+1];
            drop_entry(k + 1);
          end else begin
            k++;
          end
        end
        exp_ok.push_back(1);
        foreach (live_offsets[j])
          if (live_offsets[j] == rel) begin
            live_offsets.delete(j);
            break;
          end
      end else begin
        exp_ok.push_back(0);
      end
    end
  endfunction

  function void check_result(bit got_ok, logic [15:0] got_offset);
    bit e_ok;
    logic [15:0] e_off;
    if (exp_ok.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result ok=%0d offset=%0d", got_ok, got_offset);
      return;
    end
    e_ok = exp_ok.pop_front();
    e_off = exp_offset.pop_front();
    if (got_ok !== e_ok || got_offset !== e_off) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected ok=%0d offset=%0d, got ok=%0d offset=%0d",
                 e_ok, e_off, got_ok, got_offset);
    end
  endfunction
endclass

module tb_top;
  import wfpa_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic op;
  logic [REQ_W-1:0] request_size;
  logic [OFF_W-1:0] release_offset;
  logic out_valid;
  logic out_ready;
  logic ok;
  logic [OFF_W-1:0] data_offset;
  logic cfg_we;
  logic cfg_index;
  logic [TOT_W-1:0] cfg_wdata;

  alloc_scoreboard heap_sb;
  bit sender_idles;
  bit receiver_idles;
  bit hold_receiver;
  int sent;

  worst_fit_partition_allocator i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .request_size(request_size), .release_offset(release_offset),
    .out_valid(out_valid), .out_ready(out_ready),
    .ok(ok), .data_offset(data_offset),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // The valid stays high at the end so a following transaction can start at once.
  task automatic send_request(bit o, int unsigned req, int unsigned rel);
    int gap;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    op <= o;
    request_size <= req[16:0];
    release_offset <= rel[15:0];
    do @(posedge clk); while (!in_ready);
    heap_sb.note_request(o, req & 17'h1ffff, rel & 16'hffff);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (heap_sb.exp_ok.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(bit idx, int unsigned value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= value[16:0];
    @(negedge clk);
    cfg_we <= 0;
    heap_sb.set_reg(idx, value);
    @(negedge clk);
  endtask

  // Mostly allocations and frees of live offsets, with some noise.
  task automatic random_request();
    int unsigned pick, req;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      case ($urandom_range(0, 4))
        0: req = $urandom_range(0, 8);
        1, 2: req = $urandom_range(1, 256);
        3: req = $urandom_range(1, 2048);
        default: req = $urandom_range(0, 17'h1ffff);
      endcase
      send_request(OP_ALLOC, req, $urandom_range(0, 16'hffff));
    end else if (pick < 90 && heap_sb.live_offsets.size() != 0) begin
      send_request(OP_FREE, $urandom_range(0, 17'h1ffff),
                   heap_sb.live_offsets[$urandom_range(0, heap_sb.live_offsets.size() - 1)]);
    end else begin
      send_request(OP_FREE, $urandom_range(0, 17'h1ffff), $urandom_range(0, 16'hffff));
    end
  endtask

  always @(negedge clk) begin
    if (rst || hold_receiver) out_ready <= 0;
    else if (receiver_idles && $urandom_range(0, 5) == 0) out_ready <= 0;
    else out_ready <= 1;
  end

  always @(posedge clk)
    if (!rst && out_valid && out_ready) heap_sb.check_result(ok, data_offset);

  initial begin
    heap_sb = new();
    rst = 1;
    in_valid = 0;
    op = 0;
    request_size = 0;
    release_offset = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    sender_idles = 1;
    receiver_idles = 1;
    hold_receiver = 0;
    sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: reset geometry, zero request, extremes, unknown free.
    send_request(OP_ALLOC, 0, 0);
    send_request(OP_ALLOC, 1, 16'hffff);
    send_request(OP_ALLOC, 17'h1ffff, 0);
    send_request(OP_ALLOC, 4030, 0);
    send_request(OP_FREE, 17'h1ffff, 16'hffff);
    send_request(OP_FREE, 0, 16);
    send_request(OP_FREE, 0, 36);
    send_request(OP_FREE, 0, 16);
    drain();
    write_reg(REG_HEADER, 64);
    write_reg(REG_TOTAL, 64);
    send_request(OP_ALLOC, 4, 0);
    drain();
    write_reg(REG_TOTAL, 17'h1ffff);
    write_reg(REG_HEADER, 4);
    send_request(OP_ALLOC, 65532, 0);
    send_request(OP_FREE, 0, 4);
    // Fill the table so later allocations are given whole.
    for (int k = 0; k < 34; k++) send_request(OP_ALLOC, 4, 0);
    drain();

    // The receiver stalls for a long stretch while requests keep coming.
    write_reg(REG_TOTAL, 4096);
    write_reg(REG_HEADER, 16);
    fork
      begin
        hold_receiver = 1;
        repeat (300) @(negedge clk);
        hold_receiver = 0;
      end
      for (int k = 0; k < 10; k++) random_request();
    join
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(REG_TOTAL, 65536); write_reg(REG_HEADER, 4); end
        1: begin write_reg(REG_TOTAL, 64); write_reg(REG_HEADER, 4); end
        2: begin write_reg(REG_TOTAL, 1024); write_reg(REG_HEADER, 127); end
        3: begin write_reg(REG_HEADER, 8); write_reg(REG_TOTAL, 2048); end
        4: begin write_reg(REG_HEADER, 64); write_reg(REG_TOTAL, 16384); end
        default: begin
          write_reg(REG_HEADER, 16);
          write_reg(REG_TOTAL, 4096);
          sender_idles = 0;
          receiver_idles = 0;
        end
      endcase
      for (int k = 0; k < 170; k++) random_request();
      drain();
    end

    if (heap_sb.errors == 0 && heap_sb.exp_ok.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// File: sim.f
rtl/wfpa_pkg.sv
rtl/wfpa_cell.sv
rtl/worst_fit_partition_allocator.sv
test/tb_top.sv
